[hw/rtl/jbfd_pkg.sv]
package jbfd_pkg;

  localparam int COUNT_BITS_DEFAULT = 10;

  localparam int MAX_LEN_BITS = 10;
  localparam int STALE_BITS   = 16;
  localparam int DEPTH_BITS   = 10;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 10'd175;
  localparam logic [STALE_BITS-1:0]   STALE_RESET   = 16'd100;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_FRAME_LEN = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STALE_LIMIT   = 1'd1;

  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [STALE_BITS-1:0] IDLE_MAX  = '1;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] ST_SKIP   = 3'd0;
  localparam logic [2:0] ST_STORED = 3'd1;
  localparam logic [2:0] ST_END    = 3'd2;
  localparam logic [2:0] ST_OVER   = 3'd3;
  localparam logic [2:0] ST_STALE  = 3'd4;
  localparam logic [2:0] ST_IDLE   = 3'd5;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] brace_depth;
    logic                  inside_string;
    logic                  escape_pending;
    logic [STALE_BITS-1:0] idle_ticks;
  } ctx_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [7:0]              data_out;
    logic [MAX_LEN_BITS-1:0] frame_len;
  } result_t;

endpackage

[hw/rtl/jbfd_cfg_regs.sv]
module jbfd_cfg_regs #(
  parameter int COUNT_BITS = jbfd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [jbfd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [jbfd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic [COUNT_BITS-1:0]               count_limit,
  output logic [jbfd_pkg::STALE_BITS-1:0]     stale_limit
);

  localparam int W = (COUNT_BITS > jbfd_pkg::MAX_LEN_BITS) ? COUNT_BITS
                                                          : jbfd_pkg::MAX_LEN_BITS;

  logic [jbfd_pkg::MAX_LEN_BITS-1:0] max_frame_len;
  logic [W-1:0]                      len_w;
  logic [W-1:0]                      mask_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= jbfd_pkg::MAX_LEN_RESET;
      stale_limit   <= jbfd_pkg::STALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        jbfd_pkg::REG_MAX_FRAME_LEN: max_frame_len <= cfg_data[jbfd_pkg::MAX_LEN_BITS-1:0];
        jbfd_pkg::REG_STALE_LIMIT:   stale_limit   <= cfg_data[jbfd_pkg::STALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // cap the length limit at what the byte counter can hold
  assign len_w       = W'(max_frame_len);
  assign mask_w      = W'((2 ** COUNT_BITS) - 1);
  assign count_limit = (len_w > mask_w) ? mask_w[COUNT_BITS-1:0] : len_w[COUNT_BITS-1:0];

endmodule

[hw/rtl/jbfd_step.sv]
module jbfd_step #(
  parameter int COUNT_BITS = jbfd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                            kind,
  input  logic [7:0]                      data_byte,
  input  logic [COUNT_BITS-1:0]           count_limit,
  input  logic [jbfd_pkg::STALE_BITS-1:0] stale_limit,
  input  logic [COUNT_BITS-1:0]           byte_count,
  input  jbfd_pkg::ctx_t                  ctx,
  output logic [COUNT_BITS-1:0]           byte_count_next,
  output jbfd_pkg::ctx_t                  ctx_next,
  output jbfd_pkg::result_t               result
);

  localparam int W = (COUNT_BITS > jbfd_pkg::MAX_LEN_BITS) ? COUNT_BITS
                                                          : jbfd_pkg::MAX_LEN_BITS;

  logic [COUNT_BITS-1:0]           count_inc;
  logic [jbfd_pkg::STALE_BITS-1:0] idle_inc;
  logic [W-1:0]                    count_w;
  logic [W-1:0]                    inc_w;
  logic                            is_space;

  assign count_inc = byte_count + COUNT_BITS'(1);
  assign count_w   = W'(byte_count);
  assign inc_w     = W'(count_inc);
  assign idle_inc  = (ctx.idle_ticks == jbfd_pkg::IDLE_MAX) ? ctx.idle_ticks
                                                           : ctx.idle_ticks + 16'd1;
  assign is_space  = (data_byte == jbfd_pkg::CH_SPACE) || (data_byte == jbfd_pkg::CH_CR) ||
                     (data_byte == jbfd_pkg::CH_LF);

  always_comb begin
    byte_count_next = byte_count;
    ctx_next        = ctx;
    result.status   = jbfd_pkg::ST_IDLE;
    result.data_out = 8'd0;
    result.frame_len = '0;
    if (kind == jbfd_pkg::KIND_TICK) begin
      ctx_next.idle_ticks = idle_inc;
      if ((byte_count != '0) && (idle_inc > stale_limit)) begin
        byte_count_next         = '0;
        ctx_next.brace_depth    = '0;
        ctx_next.inside_string  = 1'b0;
        ctx_next.escape_pending = 1'b0;
        result.status           = jbfd_pkg::ST_STALE;
      end else begin
        result.status    = jbfd_pkg::ST_IDLE;
        result.frame_len = count_w[jbfd_pkg::MAX_LEN_BITS-1:0];
      end
    end else begin
      ctx_next.idle_ticks = '0;
      if ((byte_count == '0) && is_space) begin
        result.status = jbfd_pkg::ST_SKIP;
      end else if (byte_count >= count_limit) begin
        byte_count_next         = '0;
        ctx_next.brace_depth    = '0;
        ctx_next.inside_string  = 1'b0;
        ctx_next.escape_pending = 1'b0;
        result.status           = jbfd_pkg::ST_OVER;
      end else begin
        byte_count_next  = count_inc;
        result.status    = jbfd_pkg::ST_STORED;
        result.data_out  = data_byte;
        result.frame_len = inc_w[jbfd_pkg::MAX_LEN_BITS-1:0];
        if (ctx.escape_pending) begin
          ctx_next.escape_pending = 1'b0;
        end else if (ctx.inside_string && (data_byte == jbfd_pkg::CH_BSLASH)) begin
          ctx_next.escape_pending = 1'b1;
        end else if (data_byte == jbfd_pkg::CH_QUOTE) begin
          ctx_next.inside_string = !ctx.inside_string;
        end else if (!ctx.inside_string && (data_byte == jbfd_pkg::CH_OPEN)) begin
          if (ctx.brace_depth != jbfd_pkg::DEPTH_MAX) begin
            ctx_next.brace_depth = ctx.brace_depth + 10'd1;
          end
        end else if (!ctx.inside_string && (data_byte == jbfd_pkg::CH_CLOSE) &&
                     (ctx.brace_depth != '0)) begin
          ctx_next.brace_depth = ctx.brace_depth - 10'd1;
          // closing the outermost brace ends the frame
          if (ctx.brace_depth == 10'd1) begin
            result.status   = jbfd_pkg::ST_END;
            byte_count_next = '0;
          end
        end
      end
    end
  end

endmodule

[hw/rtl/json_brace_frame_detector_unit.sv]
// Channel   Handshake                  Payload
// item      item_valid / item_stall    kind, data_byte
// result    result_valid / result_stall status, data_out, frame_len
// config    cfg_we (no handshake)      cfg_index, cfg_data
//
// One result per transaction; one transaction per cycle sustained while result_stall stays low.
// Each transaction passes the input register, then the state update and result register.
// The running frame state updates as an item moves into the result register.
// rst is synchronous; it empties both registers, clears the frame state and loads defaults.
// result_stall holds a valid result register and, once the input register is full,
// raises item_stall in the same cycle.
module json_brace_frame_detector_unit #(
  parameter int COUNT_BITS = jbfd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [jbfd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [jbfd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  kind,
  input  logic [7:0]                            data_byte,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [2:0]                            status,
  output logic [7:0]                            data_out,
  output logic [jbfd_pkg::MAX_LEN_BITS-1:0]     frame_len
);

  logic [COUNT_BITS-1:0]           count_limit;
  logic [jbfd_pkg::STALE_BITS-1:0] stale_limit;

  logic                            hold_valid;
  logic                            hold_kind;
  logic [7:0]                      hold_byte;

  logic [COUNT_BITS-1:0]           byte_count;
  logic [COUNT_BITS-1:0]           byte_count_next;
  jbfd_pkg::ctx_t                  ctx;
  jbfd_pkg::ctx_t                  ctx_next;
  jbfd_pkg::result_t               step_result;

  logic                            out_free;
  logic                            advance;

  jbfd_cfg_regs #(
    .COUNT_BITS(COUNT_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .count_limit(count_limit),
    .stale_limit(stale_limit)
  );

  jbfd_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .kind           (hold_kind),
    .data_byte      (hold_byte),
    .count_limit    (count_limit),
    .stale_limit    (stale_limit),
    .byte_count     (byte_count),
    .ctx            (ctx),
    .byte_count_next(byte_count_next),
    .ctx_next       (ctx_next),
    .result         (step_result)
  );

  assign out_free   = !result_valid || !result_stall;
  assign advance    = hold_valid && out_free;
  assign item_stall = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      hold_kind <= kind;
      hold_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      ctx        <= '0;
    end else if (advance) begin
      byte_count <= byte_count_next;
      ctx        <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status    <= step_result.status;
      data_out  <= step_result.data_out;
      frame_len <= step_result.frame_len;
    end
  end

endmodule

[hw/rtl/jbfd_checker.sv]
module jbfd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [2:0]                        status,
  input logic [7:0]                        data_out,
  input logic [jbfd_pkg::MAX_LEN_BITS-1:0] frame_len
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result transaction dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status <= jbfd_pkg::ST_IDLE))
    else $error("undefined status code");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != jbfd_pkg::ST_STORED) && (status != jbfd_pkg::ST_END)
      |-> (data_out == 8'd0))
    else $error("data_out set on a result that passes no byte");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((status == jbfd_pkg::ST_SKIP) || (status == jbfd_pkg::ST_OVER) ||
                     (status == jbfd_pkg::ST_STALE))
      |-> (frame_len == '0))
    else $error("frame_len set on a dropped or skipped transaction");

endmodule

bind json_brace_frame_detector_unit jbfd_checker u_jbfd_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .status      (status),
  .data_out    (data_out),
  .frame_len   (frame_len)
);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

  typedef enum logic [1:0] {ROW_ITEM, ROW_SET_MAX, ROW_SET_STALE} row_op_t;

  typedef struct packed {
    row_op_t            op;
    logic               k;
    logic [7:0]         b;
    logic               typed;
    jbfd_pkg::result_t  want;
    logic [15:0]        val;
  } stim_row_t;

  localparam int DIR_ROWS       = 28;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 275;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_SPACE, 1'b1,
      '{jbfd_pkg::ST_SKIP, 8'h00, 10'd0}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_CR, 1'b1,
      '{jbfd_pkg::ST_SKIP, 8'h00, 10'd0}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_LF, 1'b1,
      '{jbfd_pkg::ST_SKIP, 8'h00, 10'd0}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_TICK, 8'hFF, 1'b1,
      '{jbfd_pkg::ST_IDLE, 8'h00, 10'd0}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_OPEN, 1'b1,
      '{jbfd_pkg::ST_STORED, jbfd_pkg::CH_OPEN, 10'd1}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_QUOTE,  1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_BSLASH, 1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_QUOTE,  1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_CLOSE,  1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_QUOTE,  1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_SPACE,  1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_CLOSE,  1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_CLOSE, 1'b1,
      '{jbfd_pkg::ST_STORED, jbfd_pkg::CH_CLOSE, 10'd1}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, 8'hFF,     1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, 8'h00,     1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_TICK, 8'h00,     1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_BSLASH, 1'b0, '0, 16'd0},
    '{ROW_SET_MAX,   jbfd_pkg::KIND_BYTE, 8'h00, 1'b0, '0, 16'd1},
    '{ROW_SET_STALE, jbfd_pkg::KIND_BYTE, 8'h00, 1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, 8'h41, 1'b1,
      '{jbfd_pkg::ST_OVER, 8'h00, 10'd0}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, 8'h42, 1'b1,
      '{jbfd_pkg::ST_STORED, 8'h42, 10'd1}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_OPEN, 1'b1,
      '{jbfd_pkg::ST_OVER, 8'h00, 10'd0}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_OPEN, 1'b1,
      '{jbfd_pkg::ST_STORED, jbfd_pkg::CH_OPEN, 10'd1}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_TICK, 8'h5A, 1'b1,
      '{jbfd_pkg::ST_STALE, 8'h00, 10'd0}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_TICK, 8'hA5, 1'b1,
      '{jbfd_pkg::ST_IDLE, 8'h00, 10'd0}, 16'd0},
    '{ROW_SET_MAX,   jbfd_pkg::KIND_BYTE, 8'h00, 1'b0, '0, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_SPACE, 1'b1,
      '{jbfd_pkg::ST_SKIP, 8'h00, 10'd0}, 16'd0},
    '{ROW_ITEM, jbfd_pkg::KIND_BYTE, jbfd_pkg::CH_OPEN, 1'b1,
      '{jbfd_pkg::ST_OVER, 8'h00, 10'd0}, 16'd0}
  };

  logic                                 clk          = 1'b0;
  logic                                 rst          = 1'b1;
  logic                                 cfg_we       = 1'b0;
  logic [jbfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index    = '0;
  logic [jbfd_pkg::CFG_DATA_BITS-1:0]   cfg_data     = '0;
  logic                                 item_valid   = 1'b0;
  logic                                 kind         = jbfd_pkg::KIND_BYTE;
  logic [7:0]                           data_byte    = '0;
  logic                                 result_stall = 1'b0;
  logic                                 item_stall;
  logic                                 result_valid;
  logic [2:0]                           status;
  logic [7:0]                           data_out;
  logic [jbfd_pkg::MAX_LEN_BITS-1:0]    frame_len;

  json_brace_frame_detector_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .data_out     (data_out),
    .frame_len    (frame_len)
  );

  logic [jbfd_pkg::MAX_LEN_BITS-1:0] max_len   = jbfd_pkg::MAX_LEN_RESET;
  logic [jbfd_pkg::STALE_BITS-1:0]   stale_lim = jbfd_pkg::STALE_RESET;
  logic [jbfd_pkg::MAX_LEN_BITS-1:0] fill      = '0;
  logic [jbfd_pkg::DEPTH_BITS-1:0]   depth     = '0;
  logic                              in_str    = 1'b0;
  logic                              escaped   = 1'b0;
  logic [jbfd_pkg::STALE_BITS-1:0]   idle      = '0;

  jbfd_pkg::result_t pending_results [$];
  int unsigned items_in    = 0;
  int unsigned results_out = 0;
  int unsigned mismatches  = 0;
  int unsigned seen_status [8];
  bit          steady      = 1'b0;
  int          hold        = 0;
  int          watchdog    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void drop_frame();
    fill    = '0;
    depth   = '0;
    in_str  = 1'b0;
    escaped = 1'b0;
  endfunction

  function automatic jbfd_pkg::result_t framer_next(logic k, logic [7:0] b);
    jbfd_pkg::result_t r;
    r = '0;
    if (k == jbfd_pkg::KIND_TICK) begin
      if (idle != jbfd_pkg::IDLE_MAX) idle++;
      if (fill != 0 && idle > stale_lim) begin
        drop_frame();
        r.status = jbfd_pkg::ST_STALE;
      end else begin
        r.status    = jbfd_pkg::ST_IDLE;
        r.frame_len = fill;
      end
    end else begin
      idle = '0;
      if (fill == 0 && (b == jbfd_pkg::CH_SPACE || b == jbfd_pkg::CH_CR ||
                        b == jbfd_pkg::CH_LF)) begin
        r.status = jbfd_pkg::ST_SKIP;
      end else if (fill >= max_len) begin
        drop_frame();
        r.status = jbfd_pkg::ST_OVER;
      end else begin
        fill++;
        r.status    = jbfd_pkg::ST_STORED;
        r.data_out  = b;
        r.frame_len = fill;
        if (escaped) begin
          escaped = 1'b0;
        end else if (in_str && b == jbfd_pkg::CH_BSLASH) begin
          escaped = 1'b1;
        end else if (b == jbfd_pkg::CH_QUOTE) begin
          in_str = !in_str;
        end else if (!in_str && b == jbfd_pkg::CH_OPEN) begin
          if (depth != jbfd_pkg::DEPTH_MAX) depth++;
        end else if (!in_str && b == jbfd_pkg::CH_CLOSE && depth != 0) begin
          depth--;
          if (depth == 0) begin
            r.status = jbfd_pkg::ST_END;
            fill     = '0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic match_field(string what, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    jbfd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d data %0d len %0d",
                 $time, status, data_out, frame_len);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        seen_status[want.status]++;
        match_field("status", 10'(want.status), 10'(status));
        match_field("data_out", 10'(want.data_out), 10'(data_out));
        match_field("frame_len", want.frame_len, frame_len);
      end
      hold = steady ? 0 : $urandom_range(0, 5);
    end else if (hold > 0) begin
      hold--;
    end
    result_stall <= (hold > 0);
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) watchdog = 0;
    else watchdog++;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, watchdog);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic offer(logic k, logic [7:0] b, logic typed, jbfd_pkg::result_t want);
    int                gap;
    jbfd_pkg::result_t pred;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    data_byte  <= b;
    do @(posedge clk); while (item_stall);
    pred = framer_next(k, b);
    pending_results.push_back(typed ? want : pred);
    items_in++;
  endtask

  task automatic push_byte(logic [7:0] b);
    offer(jbfd_pkg::KIND_BYTE, b, 1'b0, '0);
  endtask

  task automatic push_tick();
    offer(jbfd_pkg::KIND_TICK, 8'($urandom), 1'b0, '0);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [jbfd_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == jbfd_pkg::REG_MAX_FRAME_LEN) max_len = val[jbfd_pkg::MAX_LEN_BITS-1:0];
    else stale_lim = val;
    @(posedge clk);
  endtask

  task automatic send_string();
    logic [7:0] c;
    push_byte(jbfd_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        push_byte(jbfd_pkg::CH_BSLASH);
        push_byte(c);
      end else begin
        push_byte((c == jbfd_pkg::CH_QUOTE || c == jbfd_pkg::CH_BSLASH) ? 8'h61 : c);
      end
    end
    push_byte(jbfd_pkg::CH_QUOTE);
  endtask

  task automatic send_frame();
    int depth_now;
    int body;
    int sent;
    int r;
    int n;
    bit broken;
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(0, 2);
      push_byte(r == 0 ? jbfd_pkg::CH_SPACE : (r == 1 ? jbfd_pkg::CH_CR : jbfd_pkg::CH_LF));
    end
    push_byte(jbfd_pkg::CH_OPEN);
    depth_now = 1;
    sent      = 0;
    body      = $urandom_range(1, 40);
    broken    = ($urandom_range(0, 9) == 0);
    while (depth_now > 0 && !(broken && sent >= body)) begin
      r = $urandom_range(0, 99);
      if (sent >= body || (depth_now > 6 && r < 50)) begin
        push_byte(jbfd_pkg::CH_CLOSE);
        depth_now--;
      end else if (r < 8) begin
        push_tick();
      end else if (r < 26) begin
        push_byte(jbfd_pkg::CH_OPEN);
        depth_now++;
      end else if (r < 42) begin
        push_byte(jbfd_pkg::CH_CLOSE);
        depth_now--;
      end else if (r < 58) begin
        send_string();
      end else begin
        push_byte(8'($urandom));
      end
      sent++;
    end
    if (broken) begin
      if (stale_lim > 300) n = 4;
      else if ($urandom_range(0, 1) == 1) n = int'(stale_lim) + 1;
      else n = $urandom_range(0, int'(stale_lim));
      repeat (n) push_tick();
    end
  endtask

  initial begin
    logic [15:0] phase_max   [PHASES];
    logic [15:0] phase_stale [PHASES];
    int unsigned goal;
    int          r;
    phase_max   = '{16'd1023, 16'd1, 16'd4, 16'd175, 16'($urandom_range(2, 40)), 16'd1023};
    phase_stale = '{16'd65535, 16'd1, 16'd2, 16'd100, 16'($urandom_range(1, 8)), 16'd3};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      case (dir_tab[i].op)
        ROW_ITEM: begin
          offer(dir_tab[i].k, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
        end
        ROW_SET_MAX: begin
          settle();
          write_reg(jbfd_pkg::REG_MAX_FRAME_LEN, dir_tab[i].val);
        end
        default: begin
          settle();
          write_reg(jbfd_pkg::REG_STALE_LIMIT, dir_tab[i].val);
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(jbfd_pkg::REG_MAX_FRAME_LEN, phase_max[p]);
      write_reg(jbfd_pkg::REG_STALE_LIMIT, phase_stale[p]);
      steady = (p == 2);
      goal   = items_in + PHASE_ITEMS;
      while (items_in < goal) begin
        r = $urandom_range(0, 19);
        if (r < 16) send_frame();
        else if (r < 18) push_byte(8'($urandom));
        else repeat ($urandom_range(1, 6)) push_tick();
      end
    end

    settle();
    $display("%0d transactions in, %0d out: %0d frame ends, %0d overflows, %0d stale drops",
             items_in, results_out, seen_status[jbfd_pkg::ST_END],
             seen_status[jbfd_pkg::ST_OVER], seen_status[jbfd_pkg::ST_STALE]);
    $display("%0d skipped blanks, %0d idle ticks over %0d register settings",
             seen_status[jbfd_pkg::ST_SKIP], seen_status[jbfd_pkg::ST_IDLE], 2 * PHASES + 3);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/jbfd_pkg.sv
hw/rtl/jbfd_cfg_regs.sv
hw/rtl/jbfd_step.sv
hw/rtl/json_brace_frame_detector_unit.sv
hw/rtl/jbfd_checker.sv
bench/tb.sv
